>>> design/assert_macros.svh
// Assertion macros used by the sequencer, brc_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/brc_pkg.sv
// Shared constants, types and codes of the rectangle cover block
package brc_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 7;
	localparam int CFG_W      = 7;
	localparam int POS_W      = 12;
	localparam int PROD_W     = 13;
	localparam int GRP_SIZE   = 8;
	localparam int NGRP       = MAX_WIDTH / GRP_SIZE;
	localparam int GRP_IDX_W  = $clog2(NGRP);
	localparam int BIT_IDX_W  = $clog2(GRP_SIZE);

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_REQUEST = 1'b1
	} action_t;

	typedef logic [MAX_WIDTH-1:0] row_t;

	typedef struct packed {
		logic             rd_en;
		logic [ROW_W-1:0] rd_addr;
		logic             wr_en;
		logic [ROW_W-1:0] wr_addr;
		row_t             wr_mask;
		row_t             wr_data;
	} img_ctl_t;

	typedef struct packed {
		logic             clr_all;
		logic             rd_en;
		logic [ROW_W-1:0] rd_addr;
		logic             wr_en;
		logic [ROW_W-1:0] wr_addr;
		row_t             wr_data;
	} mark_ctl_t;

	typedef struct packed {
		logic [COL_W-1:0]  x;
		logic [ROW_W-1:0]  y;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              done;
	} rect_t;

endpackage

>>> design/bitmap_rectangle_cover.sv
// Top level of the bitmap rectangle cover: configuration, handshakes and result register
// A pixel load runs a 12-step shift-subtract divider that turns the linear load position
// into row and column, then writes the bit in S_LD_WRITE. A rectangle request reads and
// evaluates each image row in S_SC_READ and S_SC_EVAL up to and including the row of the
// next uncovered black pixel, locates that pixel and the end of its run in the shared
// lowest-set-bit finder (S_SC_FIND, S_WD_SET, S_WD_FIND), reads and tests every row of
// the rectangle and the row that ends it, if any, in S_HT_READ and S_HT_EVAL, and posts
// the result through S_FINISH and S_OUT before it returns to idle. A done answer scans the
// remaining rows and goes through S_DONE. The rate is set by the single read port of the
// image and mark stores, which are read one row at a time. The block takes no new
// transaction while a request or load is in progress; a finished result waits in the output
// register, so the next transaction is accepted while it is still stalled, and a second
// result holds the sequencer until that register frees. Loading pixel 0 clears all marks
// at once and restarts the scan.
module bitmap_rectangle_cover (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [brc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic                        pixel_black,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [brc_pkg::COL_W-1:0]   rect_x,
	output logic [brc_pkg::ROW_W-1:0]   rect_y,
	output logic [brc_pkg::SIZE_W-1:0]  rect_width,
	output logic [brc_pkg::SIZE_W-1:0]  rect_height,
	output logic                        done_res
);

	logic [brc_pkg::CFG_W-1:0] cfg_width_q;
	logic [brc_pkg::CFG_W-1:0] cfg_height_q;
	logic [brc_pkg::CFG_W-1:0] w_eff;
	logic [brc_pkg::CFG_W-1:0] h_eff;

	logic                      busy;
	logic                      in_take;
	logic                      res_valid;
	logic                      res_take;
	brc_pkg::rect_t            res;
	brc_pkg::rect_t            out_q;
	logic                      out_valid_q;

	brc_pkg::img_ctl_t         img_ctl;
	brc_pkg::row_t             img_rd;
	brc_pkg::mark_ctl_t        mark_ctl;
	brc_pkg::row_t             mark_rd;
	brc_pkg::row_t             fo_vec;
	logic                      fo_found;
	logic [brc_pkg::COL_W-1:0] fo_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= brc_pkg::CFG_W'(brc_pkg::MAX_WIDTH);
			cfg_height_q <= brc_pkg::CFG_W'(brc_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				brc_pkg::REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data;
				brc_pkg::REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (cfg_width_q == '0) begin
			w_eff = brc_pkg::CFG_W'(1);
		end else if (cfg_width_q > brc_pkg::CFG_W'(brc_pkg::MAX_WIDTH)) begin
			w_eff = brc_pkg::CFG_W'(brc_pkg::MAX_WIDTH);
		end else begin
			w_eff = cfg_width_q;
		end
		priority if (cfg_height_q == '0) begin
			h_eff = brc_pkg::CFG_W'(1);
		end else if (cfg_height_q > brc_pkg::CFG_W'(brc_pkg::MAX_HEIGHT)) begin
			h_eff = brc_pkg::CFG_W'(brc_pkg::MAX_HEIGHT);
		end else begin
			h_eff = cfg_height_q;
		end
	end

	assign in_stall = busy;
	assign in_take  = in_valid && !busy;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	brc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.in_action (brc_pkg::action_t'(action)),
		.in_pixel  (pixel_black),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.img_ctl   (img_ctl),
		.img_rd    (img_rd),
		.mark_ctl  (mark_ctl),
		.mark_rd   (mark_rd),
		.fo_vec    (fo_vec),
		.fo_found  (fo_found),
		.fo_idx    (fo_idx)
	);

	brc_first_one u_first_one (
		.clk   (clk),
		.vec   (fo_vec),
		.found (fo_found),
		.idx   (fo_idx)
	);

	brc_image_mem u_image_mem (
		.clk     (clk),
		.ctl     (img_ctl),
		.rd_data (img_rd)
	);

	brc_mark_mem u_mark_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mark_ctl),
		.rd_data (mark_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign rect_x      = out_q.x;
	assign rect_y      = out_q.y;
	assign rect_width  = out_q.width;
	assign rect_height = out_q.height;
	assign done_res    = out_q.done;

endmodule

>>> design/brc_image_mem.sv
// Image store: one row of pixels per word, bit-masked write, registered read
module brc_image_mem (
	input  logic                clk,
	input  brc_pkg::img_ctl_t   ctl,
	output brc_pkg::row_t       rd_data
);

	brc_pkg::row_t mem [brc_pkg::MAX_HEIGHT];
	brc_pkg::row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			for (int i = 0; i < brc_pkg::MAX_WIDTH; i++) begin
				if (ctl.wr_mask[i]) begin
					mem[ctl.wr_addr][i] <= ctl.wr_data[i];
				end
			end
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/brc_mark_mem.sv
// Mark store: covered pixels per row, row valid bits give the cleared state
module brc_mark_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  brc_pkg::mark_ctl_t  ctl,
	output brc_pkg::row_t       rd_data
);

	brc_pkg::row_t                 mem [brc_pkg::MAX_HEIGHT];
	logic [brc_pkg::MAX_HEIGHT-1:0] valid_q;
	brc_pkg::row_t                 rd_data_q;
	logic                          rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q  <= mem[ctl.rd_addr];
			rd_valid_q <= valid_q[ctl.rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

>>> design/brc_first_one.sv
// Search for the lowest set bit of a row: registered group search, then bit search
module brc_first_one (
	input  logic                      clk,
	input  brc_pkg::row_t             vec,
	output logic                      found,
	output logic [brc_pkg::COL_W-1:0] idx
);

	function automatic logic [brc_pkg::BIT_IDX_W-1:0] first_bit(
		input logic [brc_pkg::GRP_SIZE-1:0] v);
		logic [brc_pkg::BIT_IDX_W-1:0] r;
		r = '0;
		for (int i = brc_pkg::GRP_SIZE - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = brc_pkg::BIT_IDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [brc_pkg::GRP_IDX_W-1:0] first_grp(
		input logic [brc_pkg::NGRP-1:0] v);
		logic [brc_pkg::GRP_IDX_W-1:0] r;
		r = '0;
		for (int i = brc_pkg::NGRP - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = brc_pkg::GRP_IDX_W'(i);
			end
		end
		return r;
	endfunction

	logic [brc_pkg::NGRP-1:0]      grp_nz;
	logic [brc_pkg::GRP_IDX_W-1:0] grp;
	logic                          any_s1;
	logic [brc_pkg::GRP_IDX_W-1:0] grp_s1;
	logic [brc_pkg::GRP_SIZE-1:0]  byte_s1;

	always_comb begin
		for (int g = 0; g < brc_pkg::NGRP; g++) begin
			grp_nz[g] = |vec[g*brc_pkg::GRP_SIZE +: brc_pkg::GRP_SIZE];
		end
	end

	assign grp = first_grp(grp_nz);

	always_ff @(posedge clk) begin
		any_s1  <= |grp_nz;
		grp_s1  <= grp;
		byte_s1 <= vec[grp*brc_pkg::GRP_SIZE +: brc_pkg::GRP_SIZE];
	end

	assign found = any_s1;
	assign idx   = {grp_s1, first_bit(byte_s1)};

endmodule

>>> design/brc_seq.sv
// Sequencer: pixel loads through a shift-subtract divider, rectangle search and marking
`include "assert_macros.svh"

module brc_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_take,
	input  brc_pkg::action_t           in_action,
	input  logic                       in_pixel,
	input  logic [brc_pkg::CFG_W-1:0]  w_eff,
	input  logic [brc_pkg::CFG_W-1:0]  h_eff,
	output logic                       busy,
	output logic                       res_valid,
	output brc_pkg::rect_t             res,
	input  logic                       res_take,
	output brc_pkg::img_ctl_t          img_ctl,
	input  brc_pkg::row_t              img_rd,
	output brc_pkg::mark_ctl_t         mark_ctl,
	input  brc_pkg::row_t              mark_rd,
	output brc_pkg::row_t              fo_vec,
	input  logic                       fo_found,
	input  logic [brc_pkg::COL_W-1:0]  fo_idx
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_LD_DIV   = 13'b0000000000010,
		S_LD_WRITE = 13'b0000000000100,
		S_SC_READ  = 13'b0000000001000,
		S_SC_EVAL  = 13'b0000000010000,
		S_SC_FIND  = 13'b0000000100000,
		S_WD_SET   = 13'b0000001000000,
		S_WD_FIND  = 13'b0000010000000,
		S_HT_READ  = 13'b0000100000000,
		S_HT_EVAL  = 13'b0001000000000,
		S_FINISH   = 13'b0010000000000,
		S_DONE     = 13'b0100000000000,
		S_OUT      = 13'b1000000000000
	} state_t;

	localparam int CNT_W = $clog2(brc_pkg::POS_W);

	function automatic brc_pkg::row_t ge_mask(input logic [brc_pkg::SIZE_W-1:0] v);
		brc_pkg::row_t m;
		for (int i = 0; i < brc_pkg::MAX_WIDTH; i++) begin
			m[i] = (brc_pkg::SIZE_W'(i) >= v);
		end
		return m;
	endfunction

	function automatic brc_pkg::row_t lt_mask(input logic [brc_pkg::SIZE_W-1:0] v);
		brc_pkg::row_t m;
		for (int i = 0; i < brc_pkg::MAX_WIDTH; i++) begin
			m[i] = (brc_pkg::SIZE_W'(i) < v);
		end
		return m;
	endfunction

	state_t                        state_q;
	logic [brc_pkg::POS_W-1:0]     load_pos_q;
	logic [brc_pkg::POS_W-1:0]     pos_q;
	logic                          pix_q;
	logic [brc_pkg::POS_W-1:0]     dvd_q;
	logic [brc_pkg::COL_W-1:0]     rem_q;
	logic [brc_pkg::POS_W-1:0]     quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [brc_pkg::COL_W-1:0]     scan_col_q;
	logic [brc_pkg::SIZE_W-1:0]    scan_row_q;
	logic [brc_pkg::COL_W-1:0]     rect_x_q;
	logic [brc_pkg::ROW_W-1:0]     rect_y_q;
	logic [brc_pkg::SIZE_W-1:0]    wd_q;
	logic [brc_pkg::SIZE_W-1:0]    ht_q;
	logic [brc_pkg::SIZE_W-1:0]    row_q;
	brc_pkg::row_t                 span_q;
	logic                          done_q;

	logic [brc_pkg::PROD_W-1:0]    total;
	logic [brc_pkg::POS_W-1:0]     pos_start;
	logic [brc_pkg::PROD_W-1:0]    pos_inc;
	logic [brc_pkg::SIZE_W-1:0]    rem_sh;
	logic                          rem_ge;
	logic [brc_pkg::SIZE_W-1:0]    rem_nx;
	brc_pkg::row_t                 wmask;
	brc_pkg::row_t                 cand;
	brc_pkg::row_t                 width_vec;
	logic [brc_pkg::SIZE_W-1:0]    run_end;
	logic                          row_full;

	assign total     = brc_pkg::PROD_W'(w_eff) * brc_pkg::PROD_W'(h_eff);
	assign pos_start = (brc_pkg::PROD_W'(load_pos_q) >= total) ? '0 : load_pos_q;
	assign pos_inc   = brc_pkg::PROD_W'(pos_q) + brc_pkg::PROD_W'(1);
	assign rem_sh    = {rem_q, dvd_q[brc_pkg::POS_W-1]};
	assign rem_ge    = (rem_sh >= w_eff);
	assign rem_nx    = rem_ge ? (rem_sh - w_eff) : rem_sh;
	assign wmask     = brc_pkg::row_t'(1) << rem_q;
	assign cand      = img_rd & ~mark_rd & ge_mask({1'b0, scan_col_q}) & lt_mask(w_eff);
	assign width_vec = (~img_rd & ge_mask({1'b0, rect_x_q})) | ~lt_mask(w_eff);
	assign run_end   = fo_found ? {1'b0, fo_idx} : brc_pkg::SIZE_W'(brc_pkg::MAX_WIDTH);
	assign row_full  = ((img_rd & span_q) == span_q);

	always_comb begin
		img_ctl          = '0;
		mark_ctl         = '0;
		fo_vec           = '0;
		img_ctl.wr_addr  = quo_q[brc_pkg::ROW_W-1:0];
		img_ctl.wr_mask  = wmask;
		img_ctl.wr_data  = pix_q ? wmask : '0;
		mark_ctl.wr_addr = row_q[brc_pkg::ROW_W-1:0];
		mark_ctl.wr_data = mark_rd | span_q;
		unique case (state_q)
			S_IDLE: begin
				mark_ctl.clr_all = in_take && (in_action == brc_pkg::ACT_LOAD) &&
					(pos_start == '0);
			end
			S_LD_WRITE: begin
				img_ctl.wr_en = 1'b1;
			end
			S_SC_READ: begin
				img_ctl.rd_en    = (scan_row_q < h_eff);
				img_ctl.rd_addr  = scan_row_q[brc_pkg::ROW_W-1:0];
				mark_ctl.rd_en   = (scan_row_q < h_eff);
				mark_ctl.rd_addr = scan_row_q[brc_pkg::ROW_W-1:0];
			end
			S_SC_EVAL: begin
				fo_vec = cand;
			end
			S_WD_SET: begin
				fo_vec = width_vec;
			end
			S_HT_READ: begin
				img_ctl.rd_en    = (row_q < h_eff);
				img_ctl.rd_addr  = row_q[brc_pkg::ROW_W-1:0];
				mark_ctl.rd_en   = (row_q < h_eff);
				mark_ctl.rd_addr = row_q[brc_pkg::ROW_W-1:0];
			end
			S_HT_EVAL: begin
				mark_ctl.wr_en = row_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_pos_q <= '0;
			scan_col_q <= '0;
			scan_row_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						unique case (in_action)
							brc_pkg::ACT_LOAD: begin
								if (pos_start == '0) begin
									scan_col_q <= '0;
									scan_row_q <= '0;
								end
								state_q <= S_LD_DIV;
							end
							brc_pkg::ACT_REQUEST: begin
								state_q <= S_SC_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LD_DIV: begin
					if (cnt_q == CNT_W'(brc_pkg::POS_W - 1)) begin
						state_q <= S_LD_WRITE;
					end
				end
				S_LD_WRITE: begin
					load_pos_q <= (pos_inc >= total) ? '0 : pos_inc[brc_pkg::POS_W-1:0];
					state_q    <= S_IDLE;
				end
				S_SC_READ: begin
					state_q <= (scan_row_q < h_eff) ? S_SC_EVAL : S_DONE;
				end
				S_SC_EVAL: begin
					if (cand == '0) begin
						scan_row_q <= scan_row_q + brc_pkg::SIZE_W'(1);
						scan_col_q <= '0;
						state_q    <= S_SC_READ;
					end else begin
						state_q <= S_SC_FIND;
					end
				end
				S_SC_FIND: begin
					state_q <= S_WD_SET;
				end
				S_WD_SET: begin
					state_q <= S_WD_FIND;
				end
				S_WD_FIND: begin
					state_q <= S_HT_READ;
				end
				S_HT_READ: begin
					state_q <= (row_q < h_eff) ? S_HT_EVAL : S_FINISH;
				end
				S_HT_EVAL: begin
					state_q <= row_full ? S_HT_READ : S_FINISH;
				end
				S_FINISH: begin
					if (({1'b0, rect_x_q} + brc_pkg::SIZE_W'(1)) < w_eff) begin
						scan_col_q <= rect_x_q + brc_pkg::COL_W'(1);
						scan_row_q <= {1'b0, rect_y_q};
					end else begin
						scan_col_q <= '0;
						scan_row_q <= {1'b0, rect_y_q} + brc_pkg::SIZE_W'(1);
					end
					state_q <= S_OUT;
				end
				S_DONE: begin
					scan_row_q <= h_eff;
					scan_col_q <= '0;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pos_q <= pos_start;
				dvd_q <= pos_start;
				pix_q <= in_pixel;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			S_LD_DIV: begin
				rem_q <= rem_nx[brc_pkg::COL_W-1:0];
				quo_q <= {quo_q[brc_pkg::POS_W-2:0], rem_ge};
				dvd_q <= {dvd_q[brc_pkg::POS_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_SC_FIND: begin
				rect_x_q <= fo_idx;
				rect_y_q <= scan_row_q[brc_pkg::ROW_W-1:0];
			end
			S_WD_FIND: begin
				wd_q   <= run_end - {1'b0, rect_x_q};
				span_q <= ge_mask({1'b0, rect_x_q}) & lt_mask(run_end);
				ht_q   <= '0;
				row_q  <= {1'b0, rect_y_q};
			end
			S_HT_EVAL: begin
				if (row_full) begin
					ht_q  <= ht_q + brc_pkg::SIZE_W'(1);
					row_q <= row_q + brc_pkg::SIZE_W'(1);
				end
			end
			S_FINISH: begin
				done_q <= 1'b0;
			end
			S_DONE: begin
				done_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);

	always_comb begin
		if (done_q) begin
			res      = '0;
			res.done = 1'b1;
		end else begin
			res.x      = rect_x_q;
			res.y      = rect_y_q;
			res.width  = wd_q;
			res.height = ht_q;
			res.done   = 1'b0;
		end
	end

	`ASSERT_PROP(a_rect_nonempty, clk, arst_n, res_valid && !res.done |-> res.width != '0 && res.height != '0, "rectangle result with zero size")
	`ASSERT_PROP(a_rect_in_cols, clk, arst_n, res_valid && !res.done |-> (8'(res.x) + 8'(res.width)) <= 8'(w_eff), "rectangle runs past the image width")
	`ASSERT_PROP(a_rect_in_rows, clk, arst_n, res_valid && !res.done |-> (8'(res.y) + 8'(res.height)) <= 8'(h_eff), "rectangle runs past the image height")
	`ASSERT_PROP(a_load_row, clk, arst_n, img_ctl.wr_en |-> quo_q < brc_pkg::POS_W'(h_eff), "pixel load row beyond the image")
	`ASSERT_NEVER(a_mark_clear_busy, clk, arst_n, mark_ctl.clr_all && (mark_ctl.wr_en || state_q != S_IDLE), "mark clear outside an idle load")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_rectangle_cover: directed table, random images, predictor
module testbench;
	import brc_pkg::*;

	localparam int ITEM_TARGET = 630;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 600;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [6:0] CORNER_W [5] = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd65};
	localparam logic [6:0] CORNER_H [5] = '{7'd2, 7'd64, 7'd1, 7'd100, 7'd0};
	localparam rect_t NO_RECT = '0;
	localparam rect_t DONE_RECT = '{x: '0, y: '0, width: '0, height: '0, done: 1'b1};

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [0:0] reg_sel;
		logic [6:0] reg_val;
		action_t    act;
		logic       pix;
		bit         typed;
		rect_t      want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic                action;
	logic                pixel_black;
	logic                out_valid;
	logic                out_stall;
	logic [COL_W-1:0]    rect_x;
	logic [ROW_W-1:0]    rect_y;
	logic [SIZE_W-1:0]   rect_width;
	logic [SIZE_W-1:0]   rect_height;
	logic                done_res;

	row_t       img_rows [MAX_HEIGHT];
	row_t       cover_rows [MAX_HEIGHT] = '{default: '0};
	row_t       loaded_rows [MAX_HEIGHT] = '{default: '0};
	int         load_pos = 0;
	int         scan_col = 0;
	int         scan_row = 0;
	logic [6:0] width_reg = 7'd64;
	logic [6:0] height_reg = 7'd64;

	rect_t pending_rects [$];
	bit    cur_typed = 1'b0;
	rect_t cur_typed_rect = '0;
	bit    tx_steady = 1'b0;
	bit    squeeze_req = 1'b0;
	int    items_sent = 0;
	int    mismatches = 0;
	int    quiet_cycles = 0;

	bitmap_rectangle_cover dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.pixel_black (pixel_black),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.done_res    (done_res)
	);

	always #6 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int clamp_size(input logic [6:0] raw, input int max);
		if (raw == 0) return 1;
		if (raw > max) return max;
		return int'(raw);
	endfunction

	function automatic int size_w();
		return clamp_size(width_reg, MAX_WIDTH);
	endfunction

	function automatic int size_h();
		return clamp_size(height_reg, MAX_HEIGHT);
	endfunction

	function automatic bit region_loaded();
		int w, h;
		w = size_w();
		h = size_h();
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				if (!loaded_rows[r][c]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit predict_cover(input action_t act, input logic pix, output rect_t res);
		int w, h, total, pos, x, y, wd, ht, run;
		bit hit;
		w = size_w();
		h = size_h();
		res = '0;
		if (act == ACT_LOAD) begin
			total = w * h;
			pos = (load_pos >= total) ? 0 : load_pos;
			if (pos == 0) begin
				foreach (cover_rows[i]) cover_rows[i] = '0;
				scan_col = 0;
				scan_row = 0;
			end
			img_rows[pos / w][pos % w] = pix;
			loaded_rows[pos / w][pos % w] = 1'b1;
			pos++;
			load_pos = (pos >= total) ? 0 : pos;
			return 1'b0;
		end
		x = scan_col;
		y = scan_row;
		hit = 1'b0;
		while (!hit && y < h) begin
			while (!hit && x < w) begin
				if (img_rows[y][x] && !cover_rows[y][x]) hit = 1'b1;
				else x++;
			end
			if (!hit) begin
				y++;
				x = 0;
			end
		end
		if (!hit) begin
			scan_row = h;
			scan_col = 0;
			res.done = 1'b1;
			return 1'b1;
		end
		wd = 0;
		ht = h + 1;
		while (x + wd < w && img_rows[y][x + wd]) begin
			run = 0;
			while (y + run < h && img_rows[y + run][x + wd]) run++;
			if (run < ht) ht = run;
			wd++;
		end
		for (int r = 0; r < ht; r++)
			for (int c = 0; c < wd; c++)
				cover_rows[y + r][x + c] = 1'b1;
		if (x + 1 < w) begin
			scan_col = x + 1;
			scan_row = y;
		end else begin
			scan_col = 0;
			scan_row = y + 1;
		end
		res.x = COL_W'(x);
		res.y = ROW_W'(y);
		res.width = SIZE_W'(wd);
		res.height = SIZE_W'(ht);
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : item_track
		rect_t res;
		if (arst_n && in_valid && !in_stall) begin
			if (predict_cover(action_t'(action), pixel_black, res))
				pending_rects = {pending_rects, (cur_typed ? cur_typed_rect : res)};
		end
	end

	always @(posedge clk) begin : result_check
		rect_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rects.size() == 0) begin
				$display("%0t ns: unexpected result x=%0d y=%0d w=%0d h=%0d done=%0d",
					$time, rect_x, rect_y, rect_width, rect_height, done_res);
				mismatches++;
			end else begin
				want = pending_rects.pop_front();
				check_field("rect_x", want.x, rect_x);
				check_field("rect_y", want.y, rect_y);
				check_field("rect_width", want.width, rect_width);
				check_field("rect_height", want.height, rect_height);
				check_field("done_res", want.done, done_res);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_sink
		int hold, rx_count;
		rx_count = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = ((rx_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
			if (squeeze_req) begin
				hold = LONG_HOLD;
				squeeze_req = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			rx_count++;
		end
	end

	task automatic send_item(input action_t act, input logic pix, input bit typed,
			input rect_t typed_rect);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		cur_typed_rect = typed_rect;
		action <= act;
		pixel_black <= pix;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_rects.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] sel, input logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		if (sel == REG_IMAGE_WIDTH) width_reg = val;
		else height_reg = val;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int phase, dens, reqs, tail, roll;
		bit shrunk;
		logic [6:0] new_w, new_h;
		dir_row_t dir_rows [$];
		in_valid = 1'b0;
		action = ACT_LOAD;
		pixel_black = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		dir_rows = '{
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd3, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_WRITE, REG_IMAGE_HEIGHT, 7'd2, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b1, DONE_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b1, 1'b1, DONE_RECT},
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_WRITE, REG_IMAGE_HEIGHT, 7'd3, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b1, DONE_RECT},
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd2, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_WRITE, REG_IMAGE_HEIGHT, 7'd2, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b0, NO_RECT},
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd1, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b1, DONE_RECT},
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd2, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b1, 1'b0, NO_RECT},
			'{ROW_WRITE, REG_IMAGE_WIDTH,  7'd1, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_LOAD,    1'b0, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b1, 1'b0, NO_RECT},
			'{ROW_ITEM,  REG_IMAGE_WIDTH,  7'd0, ACT_REQUEST, 1'b0, 1'b1, DONE_RECT}
		};
		@(posedge arst_n);
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
				cfg_we <= 1'b0;
			end else begin
				send_item(dir_rows[i].act, dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase < 5) begin
				new_w = CORNER_W[phase];
				new_h = CORNER_H[phase];
			end else begin
				new_w = 7'($urandom_range(1, 8));
				new_h = 7'($urandom_range(1, 8));
			end
			tx_steady = (phase % 3 == 0);
			settle();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_WIDTH, new_w);
				write_reg(REG_IMAGE_HEIGHT, new_h);
			end else begin
				write_reg(REG_IMAGE_HEIGHT, new_h);
				write_reg(REG_IMAGE_WIDTH, new_w);
			end
			cfg_we <= 1'b0;

			// fill the whole image and leave the load position at zero
			dens = (phase == 0) ? 50 : 25 * $urandom_range(1, 4);
			while (!region_loaded() || (load_pos != 0 && load_pos < size_w() * size_h()))
				send_item(ACT_LOAD, $urandom_range(1, 100) <= dens, 1'b0, NO_RECT);

			if (phase == 0) squeeze_req = 1'b1;
			reqs = 0;
			tail = 0;
			shrunk = 1'b0;
			while (tail < 2 && reqs < 200) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					send_item(ACT_LOAD, 1'($urandom_range(0, 1)), 1'b0, NO_RECT);
				end else if (roll < 8 && !shrunk) begin
					settle();
					if ($urandom_range(0, 1))
						write_reg(REG_IMAGE_WIDTH, 7'($urandom_range(1, size_w())));
					else
						write_reg(REG_IMAGE_HEIGHT, 7'($urandom_range(1, size_h())));
					cfg_we <= 1'b0;
					shrunk = 1'b1;
				end else begin
					send_item(ACT_REQUEST, 1'($urandom_range(0, 1)), 1'b0, NO_RECT);
					reqs++;
					if (scan_row >= size_h()) tail++;
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/brc_pkg.sv
design/brc_image_mem.sv
design/brc_mark_mem.sv
design/brc_first_one.sv
design/brc_seq.sv
design/bitmap_rectangle_cover.sv
verif/testbench.sv
